// ===== design/qin_pkg.sv =====
// shared types and constants for the quaternion integrate and normalize pipeline
`default_nettype none
package qin_pkg;
    typedef logic signed [31:0] comp_t;
    typedef comp_t [3:0] quat_t;
    typedef comp_t [2:0] vec_t;
    typedef logic signed [63:0] wide_t;
    typedef wide_t [3:0] dquat_t;
    typedef logic [23:0] step_t;
    typedef logic [31:0] len_t;

    localparam step_t       TIME_STEP_RESET = 24'd279620;
    localparam logic [63:0] LEN_SQ_MIN      = 64'd29;
    localparam comp_t       ONE_Q29         = 32'sh2000_0000;

    localparam int SQRT_STEPS     = 32;
    localparam int SQRT_PER_STAGE = 2;
    localparam int SQRT_STAGES    = SQRT_STEPS / SQRT_PER_STAGE;
    localparam int QUO_W          = 30;
    localparam int DIV_PER_STAGE  = 2;
    localparam int DIV_STAGES     = QUO_W / DIV_PER_STAGE;
endpackage
`default_nettype wire

// ===== design/qin_deriv.sv =====
// hamilton product of the pure velocity quaternion and the orientation, saturating sums
`default_nettype none
module qin_deriv
    import qin_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   ce,
    input  wire logic   in_valid,
    input  wire quat_t  q,
    input  wire vec_t   w,
    output logic        out_valid,
    output quat_t       q_out,
    output dquat_t      d_out
);
    // operand of term j of component i, negated where the product enters with a minus
    function automatic logic signed [32:0] term_q(quat_t qv, int i, int j);
        comp_t v;
        logic neg;
        v = '0;
        neg = 1'b0;
        case (i)
            0: begin
                case (j)
                    0: v = qv[3];
                    1: v = qv[2];
                    default: begin v = qv[1]; neg = 1'b1; end
                endcase
            end
            1: begin
                case (j)
                    0: begin v = qv[2]; neg = 1'b1; end
                    1: v = qv[3];
                    default: v = qv[0];
                endcase
            end
            2: begin
                case (j)
                    0: v = qv[1];
                    1: begin v = qv[0]; neg = 1'b1; end
                    default: v = qv[3];
                endcase
            end
            default: begin
                neg = 1'b1;
                case (j)
                    0: v = qv[0];
                    1: v = qv[1];
                    default: v = qv[2];
                endcase
            end
        endcase
        return neg ? -33'(v) : 33'(v);
    endfunction

    function automatic wide_t sat_add(wide_t a, wide_t b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s[64] != s[63])
            return s[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
        return s[63:0];
    endfunction

    logic signed [64:0] prod [4][3];
    wide_t prod_a_reg [4][3];
    quat_t q_a_reg, q_b_reg, q_c_reg;
    wide_t sum_b_reg [4];
    wide_t last_b_reg [4];
    dquat_t d_c_reg;
    logic v_a_reg, v_b_reg, v_c_reg;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 3; j++)
                prod[i][j] = 65'(w[j]) * 65'(term_q(q, i, j));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_a_reg <= 1'b0;
            v_b_reg <= 1'b0;
            v_c_reg <= 1'b0;
        end
        else if (ce)
        begin
            v_a_reg <= in_valid;
            v_b_reg <= v_a_reg;
            v_c_reg <= v_b_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            q_a_reg <= q;
            q_b_reg <= q_a_reg;
            q_c_reg <= q_b_reg;
            for (int i = 0; i < 4; i++)
            begin
                for (int j = 0; j < 3; j++)
                    prod_a_reg[i][j] <= prod[i][j][63:0];
                sum_b_reg[i]  <= sat_add(prod_a_reg[i][0], prod_a_reg[i][1]);
                last_b_reg[i] <= prod_a_reg[i][2];
                d_c_reg[i]    <= sat_add(sum_b_reg[i], last_b_reg[i]);
            end
        end
    end

    assign out_valid = v_c_reg;
    assign q_out     = q_c_reg;
    assign d_out     = d_c_reg;
endmodule
`default_nettype wire

// ===== design/qin_advance.sv =====
// scales the derivative by half the time step and adds it to the orientation
`default_nettype none
module qin_advance
    import qin_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   ce,
    input  wire step_t  time_step,
    input  wire logic   in_valid,
    input  wire quat_t  q,
    input  wire dquat_t d,
    output logic        out_valid,
    output quat_t       r
);
    function automatic comp_t sat32(logic signed [48:0] v);
        if (v > 49'sd2147483647)
            return 32'sh7fff_ffff;
        if (v < -49'sd2147483648)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    logic signed [60:0] ph_reg [4];
    logic signed [60:0] pl_reg [4];
    quat_t q_d_reg;
    quat_t r_e_reg;
    logic v_d_reg, v_e_reg;

    logic signed [47:0] d29 [4];
    logic signed [60:0] ph_next [4];
    logic signed [60:0] pl_next [4];
    logic signed [72:0] full [4];
    logic signed [47:0] inc [4];
    logic signed [48:0] acc [4];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            d29[i]     = d[i][63:16];
            ph_next[i] = 61'(d29[i]) * 61'($signed({1'b0, time_step[23:12]}));
            pl_next[i] = 61'(d29[i]) * 61'($signed({1'b0, time_step[11:0]}));
            full[i]    = $signed({ph_reg[i], 12'b0}) + 73'(pl_reg[i]);
            inc[i]     = full[i][72:25];
            acc[i]     = 49'(q_d_reg[i]) + 49'(inc[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_d_reg <= 1'b0;
            v_e_reg <= 1'b0;
        end
        else if (ce)
        begin
            v_d_reg <= in_valid;
            v_e_reg <= v_d_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            q_d_reg <= q;
            for (int i = 0; i < 4; i++)
            begin
                ph_reg[i]  <= ph_next[i];
                pl_reg[i]  <= pl_next[i];
                r_e_reg[i] <= sat32(acc[i]);
            end
        end
    end

    assign out_valid = v_e_reg;
    assign r         = r_e_reg;
endmodule
`default_nettype wire

// ===== design/qin_sqrt.sv =====
// squared length and pipelined bitwise integer square root
`default_nettype none
module qin_sqrt
    import qin_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  ce,
    input  wire logic  in_valid,
    input  wire quat_t r,
    output logic       out_valid,
    output quat_t      r_out,
    output len_t       len,
    output logic       degen
);
    logic [63:0] sq_reg [4];
    quat_t r_f_reg;
    logic v_f_reg;

    logic [63:0] n_pipe [SQRT_STAGES+1];
    logic [63:0] res_pipe [SQRT_STAGES+1];
    quat_t r_pipe [SQRT_STAGES+1];
    logic degen_pipe [SQRT_STAGES+1];
    logic v_pipe [SQRT_STAGES+1];

    logic signed [63:0] sq_next [4];
    logic [65:0] total;
    logic [63:0] len_sq;
    logic [63:0] n_next [SQRT_STAGES];
    logic [63:0] res_next [SQRT_STAGES];

    always_comb
    begin
        logic [63:0] nn;
        logic [63:0] rr;
        logic [63:0] bitv;
        logic [64:0] trial;
        for (int i = 0; i < 4; i++)
            sq_next[i] = 64'(r[i]) * 64'(r[i]);
        total = 66'(sq_reg[0]) + 66'(sq_reg[1]) + 66'(sq_reg[2]) + 66'(sq_reg[3]);
        len_sq = (total[65:64] != 2'b00) ? {64{1'b1}} : total[63:0];
        for (int k = 0; k < SQRT_STAGES; k++)
        begin
            nn = n_pipe[k];
            rr = res_pipe[k];
            for (int s = 0; s < SQRT_PER_STAGE; s++)
            begin
                bitv  = 64'd1 << (62 - 2 * (k * SQRT_PER_STAGE + s));
                trial = {1'b0, rr} + {1'b0, bitv};
                if ({1'b0, nn} >= trial)
                begin
                    nn = nn - trial[63:0];
                    rr = (rr >> 1) + bitv;
                end
                else
                    rr = rr >> 1;
            end
            n_next[k]   = nn;
            res_next[k] = rr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_f_reg <= 1'b0;
            for (int k = 0; k <= SQRT_STAGES; k++)
                v_pipe[k] <= 1'b0;
        end
        else if (ce)
        begin
            v_f_reg   <= in_valid;
            v_pipe[0] <= v_f_reg;
            for (int k = 0; k < SQRT_STAGES; k++)
                v_pipe[k+1] <= v_pipe[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int i = 0; i < 4; i++)
                sq_reg[i] <= sq_next[i][63:0];
            r_f_reg       <= r;
            n_pipe[0]     <= len_sq;
            res_pipe[0]   <= 64'd0;
            r_pipe[0]     <= r_f_reg;
            degen_pipe[0] <= (len_sq < LEN_SQ_MIN);
            for (int k = 0; k < SQRT_STAGES; k++)
            begin
                n_pipe[k+1]     <= n_next[k];
                res_pipe[k+1]   <= res_next[k];
                r_pipe[k+1]     <= r_pipe[k];
                degen_pipe[k+1] <= degen_pipe[k];
            end
        end
    end

    assign out_valid = v_pipe[SQRT_STAGES];
    assign r_out     = r_pipe[SQRT_STAGES];
    assign len       = res_pipe[SQRT_STAGES][31:0];
    assign degen     = degen_pipe[SQRT_STAGES];
endmodule
`default_nettype wire

// ===== design/qin_div.sv =====
// pipelined restoring division of each component by the length, identity on short length
`default_nettype none
module qin_div
    import qin_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  ce,
    input  wire logic  in_valid,
    input  wire quat_t r,
    input  wire len_t  len,
    input  wire logic  degen,
    output logic       out_valid,
    output quat_t      q_out,
    output logic       degen_out
);
    typedef logic [QUO_W-1:0] quo_t;

    logic [31:0] p_pipe   [DIV_STAGES+1][4];
    quo_t        quo_pipe [DIV_STAGES+1][4];
    logic        lsb_pipe [DIV_STAGES+1][4];
    logic        neg_pipe [DIV_STAGES+1][4];
    len_t        len_pipe [DIV_STAGES+1];
    logic        degen_pipe [DIV_STAGES+1];
    logic        v_pipe [DIV_STAGES+1];
    quat_t       q_o_reg;
    logic        degen_o_reg;
    logic        v_o_reg;

    logic [31:0] mag [4];
    logic [31:0] p_next   [DIV_STAGES][4];
    quo_t        quo_next [DIV_STAGES][4];
    comp_t       res [4];

    always_comb
    begin
        logic [31:0] pp;
        logic [32:0] shifted;
        quo_t qq;
        logic in_bit;
        for (int i = 0; i < 4; i++)
            mag[i] = r[i][31] ? 32'(-r[i]) : 32'(r[i]);
        for (int k = 0; k < DIV_STAGES; k++)
        begin
            for (int i = 0; i < 4; i++)
            begin
                pp = p_pipe[k][i];
                qq = quo_pipe[k][i];
                for (int s = 0; s < DIV_PER_STAGE; s++)
                begin
                    // the magnitude's low bit enters on the first step, zeros after
                    in_bit  = (k == 0 && s == 0) ? lsb_pipe[k][i] : 1'b0;
                    shifted = {pp, in_bit};
                    if (shifted >= {1'b0, len_pipe[k]})
                    begin
                        shifted = shifted - {1'b0, len_pipe[k]};
                        qq = {qq[QUO_W-2:0], 1'b1};
                    end
                    else
                        qq = {qq[QUO_W-2:0], 1'b0};
                    pp = shifted[31:0];
                end
                p_next[k][i]   = pp;
                quo_next[k][i] = qq;
            end
        end
        for (int i = 0; i < 4; i++)
        begin
            if (degen_pipe[DIV_STAGES])
                res[i] = (i == 3) ? ONE_Q29 : 32'sd0;
            else if (neg_pipe[DIV_STAGES][i])
                res[i] = -$signed(32'(quo_pipe[DIV_STAGES][i]));
            else
                res[i] = $signed(32'(quo_pipe[DIV_STAGES][i]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= DIV_STAGES; k++)
                v_pipe[k] <= 1'b0;
            v_o_reg <= 1'b0;
        end
        else if (ce)
        begin
            v_pipe[0] <= in_valid;
            for (int k = 0; k < DIV_STAGES; k++)
                v_pipe[k+1] <= v_pipe[k];
            v_o_reg <= v_pipe[DIV_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            len_pipe[0]   <= len;
            degen_pipe[0] <= degen;
            for (int i = 0; i < 4; i++)
            begin
                p_pipe[0][i]   <= {1'b0, mag[i][31:1]};
                quo_pipe[0][i] <= '0;
                lsb_pipe[0][i] <= mag[i][0];
                neg_pipe[0][i] <= r[i][31];
            end
            for (int k = 0; k < DIV_STAGES; k++)
            begin
                len_pipe[k+1]   <= len_pipe[k];
                degen_pipe[k+1] <= degen_pipe[k];
                for (int i = 0; i < 4; i++)
                begin
                    p_pipe[k+1][i]   <= p_next[k][i];
                    quo_pipe[k+1][i] <= quo_next[k][i];
                    lsb_pipe[k+1][i] <= lsb_pipe[k][i];
                    neg_pipe[k+1][i] <= neg_pipe[k][i];
                end
            end
            for (int i = 0; i < 4; i++)
                q_o_reg[i] <= res[i];
            degen_o_reg <= degen_pipe[DIV_STAGES];
        end
    end

    assign out_valid = v_o_reg;
    assign q_out     = q_o_reg;
    assign degen_out = degen_o_reg;
endmodule
`default_nettype wire

// ===== design/quaternion_integrate_normalize_core.sv =====
// an input beat passes the deriv, advance, sqrt and div pipelines and the output register to m_tvalid
// throughput: one beat per cycle while s_tready is high; every stage of the pipeline is registered
// the output register plus one skid entry hold results while m_tready is low;
// s_tready drops only while the skid entry is occupied
// reset: rst_n clears all valid bits and loads time_step with 279620 (about 1/60 s)
`default_nettype none
module quaternion_integrate_normalize_core
    import qin_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // orient_x, orient_y, orient_z, orient_w, omega_x, omega_y, omega_z
    input  wire logic [223:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [127:0]      m_tdata,  // new_x, new_y, new_z, new_w
    output logic [0:0]        m_tuser,  // degenerate
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [23:0]  cfg_data
);
    typedef struct packed {
        logic  degen;
        quat_t q;
    } result_t;

    step_t time_step_reg;
    logic  ce;

    logic   d_valid;
    quat_t  d_q;
    dquat_t d_d;
    logic   a_valid;
    quat_t  a_r;
    logic   s_valid;
    quat_t  s_r;
    len_t   s_len;
    logic   s_degen;
    logic   v_valid;
    quat_t  v_q;
    logic   v_degen;

    result_t out_reg, skid_reg, tail;
    logic    out_v_reg, skid_v_reg;

    assign cfg_ready = 1'b1;
    assign ce        = !skid_v_reg;
    assign s_tready  = ce;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            time_step_reg <= TIME_STEP_RESET;
        else if (cfg_valid && cfg_ready)
            time_step_reg <= cfg_data;
    end

    qin_deriv u_deriv (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (s_tvalid),
        .q         (s_tdata[127:0]),
        .w         (s_tdata[223:128]),
        .out_valid (d_valid),
        .q_out     (d_q),
        .d_out     (d_d)
    );

    qin_advance u_advance (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .time_step (time_step_reg),
        .in_valid  (d_valid),
        .q         (d_q),
        .d         (d_d),
        .out_valid (a_valid),
        .r         (a_r)
    );

    qin_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (a_valid),
        .r         (a_r),
        .out_valid (s_valid),
        .r_out     (s_r),
        .len       (s_len),
        .degen     (s_degen)
    );

    qin_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (s_valid),
        .r         (s_r),
        .len       (s_len),
        .degen     (s_degen),
        .out_valid (v_valid),
        .q_out     (v_q),
        .degen_out (v_degen)
    );

    assign tail = '{degen: v_degen, q: v_q};

    // output register with one skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (skid_v_reg)
        begin
            if (m_tready)
            begin
                out_v_reg  <= 1'b1;
                skid_v_reg <= 1'b0;
            end
        end
        else if (v_valid)
        begin
            if (out_v_reg && !m_tready)
                skid_v_reg <= 1'b1;
            else
                out_v_reg <= 1'b1;
        end
        else if (m_tready)
            out_v_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (skid_v_reg)
        begin
            if (m_tready)
                out_reg <= skid_reg;
        end
        else if (v_valid)
        begin
            if (out_v_reg && !m_tready)
                skid_reg <= tail;
            else
                out_reg <= tail;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_reg.q;
    assign m_tuser  = out_reg.degen;
endmodule
`default_nettype wire

// ===== design/qin_checker.sv =====
// port-level checks for the quaternion integrate and normalize core
`default_nettype none
module qin_checker (
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic [223:0] s_tdata,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [127:0] m_tdata,
    input wire logic [0:0]   m_tuser,
    input wire logic         cfg_valid,
    input wire logic         cfg_ready,
    input wire logic [23:0]  cfg_data
);
    logic in_beat, cfg_beat;
    assign in_beat  = s_tvalid && s_tready && (s_tdata != 224'd0 || s_tdata == 224'd0);
    assign cfg_beat = cfg_valid && cfg_ready && (cfg_data != 24'd0 || cfg_data == 24'd0);

    // the valid bits are cleared asynchronously while rst_n is low
    a_reset_idle: assert property (@(posedge clk) !rst_n |=> !m_tvalid)
        else $error("output valid during reset");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled output beat changed");

    a_identity: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |->
            m_tdata[127:96] == 32'h2000_0000 && m_tdata[95:0] == 96'd0)
        else $error("degenerate beat is not the identity");

    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |->
            $signed(m_tdata[31:0]) <= 32'sd536870912
            && $signed(m_tdata[31:0]) >= -32'sd536870912
            && $signed(m_tdata[63:32]) <= 32'sd536870912
            && $signed(m_tdata[63:32]) >= -32'sd536870912
            && $signed(m_tdata[95:64]) <= 32'sd536870912
            && $signed(m_tdata[95:64]) >= -32'sd536870912
            && $signed(m_tdata[127:96]) <= 32'sd536870912
            && $signed(m_tdata[127:96]) >= -32'sd536870912)
        else $error("normalized component out of range");

    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready && !in_beat && !cfg_beat |-> m_tvalid && !$past(m_tready))
        else $error("input stalled without a stalled output");
endmodule

bind quaternion_integrate_normalize_core qin_checker u_qin_checker (.*);
`default_nettype wire

// ===== verif/quaternion_integrate_normalize_core_tb.sv =====
// self-checking testbench for the quaternion integrate and normalize core
`default_nettype none
module quaternion_integrate_normalize_core_tb;
    import qin_pkg::*;

    localparam int LIMIT_CYCLES = 600000;
    localparam int DRAIN_CYCLES = 60;

    typedef struct {
        quat_t orient;
        vec_t  omega;
    } body_t;

    typedef struct {
        quat_t q;
        bit    degen;
    } attitude_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [223:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;
    logic [0:0]   m_tuser;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [23:0]  cfg_data = '0;

    body_t     pending_bodies[$];
    attitude_t expected_attitudes[$];
    step_t     dt_shadow = TIME_STEP_RESET;
    bit        no_gaps = 1'b0;
    bit        long_hold_done = 1'b0;
    int        gap_left = 0;
    int        hold_left = 0;
    int        cycle_count = 0;
    int        mismatches = 0;
    int        beats_in = 0;
    int        beats_out = 0;
    int        degen_seen = 0;
    int        dt_writes = 0;

    quaternion_integrate_normalize_core uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    always #4 clk = ~clk;

    function automatic wide_t add_sat64(wide_t a, wide_t b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
            return s[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
        return s[63:0];
    endfunction

    function automatic comp_t clamp32(wide_t v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic wide_t mul45(comp_t a, comp_t b);
        return wide_t'(a) * wide_t'(b);
    endfunction

    // q + d * dt / 2, d in Q.45, floor rounding at each shift
    function automatic comp_t step_comp(comp_t q, wide_t d45, step_t dt);
        wide_t d29, hi, lo, inc;
        d29 = d45 >>> 16;
        hi = d29 * $signed({52'b0, dt[23:12]});
        lo = d29 * $signed({52'b0, dt[11:0]});
        inc = (hi + (lo >>> 12)) >>> 13;
        return clamp32(wide_t'(q) + inc);
    endfunction

    function automatic logic [63:0] root64(logic [63:0] n);
        logic [63:0] res, bval;
        res = '0;
        bval = 64'd1 << 62;
        for (int i = 0; i < 32; i++)
        begin
            if (n >= res + bval)
            begin
                n = n - (res + bval);
                res = (res >> 1) + bval;
            end
            else
                res = res >> 1;
            bval = bval >> 2;
        end
        return res;
    endfunction

    function automatic attitude_t integrate_attitude(body_t b, step_t dt);
        attitude_t a;
        comp_t qx, qy, qz, qw, wx, wy, wz;
        quat_t r;
        logic [65:0] acc;
        logic [63:0] s, len;
        wide_t sq, num, den;
        qx = b.orient[0]; qy = b.orient[1]; qz = b.orient[2]; qw = b.orient[3];
        wx = b.omega[0];  wy = b.omega[1];  wz = b.omega[2];
        r[0] = step_comp(qx, add_sat64(add_sat64(mul45(wx, qw), mul45(wy, qz)),
                                       -mul45(wz, qy)), dt);
        r[1] = step_comp(qy, add_sat64(add_sat64(-mul45(wx, qz), mul45(wy, qw)),
                                       mul45(wz, qx)), dt);
        r[2] = step_comp(qz, add_sat64(add_sat64(mul45(wx, qy), -mul45(wy, qx)),
                                       mul45(wz, qw)), dt);
        r[3] = step_comp(qw, add_sat64(add_sat64(-mul45(wx, qx), -mul45(wy, qy)),
                                       -mul45(wz, qz)), dt);
        acc = '0;
        for (int i = 0; i < 4; i++)
        begin
            sq = wide_t'(r[i]) * wide_t'(r[i]);
            acc = acc + {2'b0, sq};
        end
        s = (acc > {2'b0, {64{1'b1}}}) ? {64{1'b1}} : acc[63:0];
        a.degen = (s < LEN_SQ_MIN);
        if (a.degen)
        begin
            a.q[0] = '0; a.q[1] = '0; a.q[2] = '0; a.q[3] = ONE_Q29;
        end
        else
        begin
            len = root64(s);
            den = $signed(len);
            for (int i = 0; i < 4; i++)
            begin
                num = wide_t'(r[i]) <<< 29;
                a.q[i] = clamp32(num / den);
            end
        end
        return a;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(99);
        if (no_gaps || p < 60)
            return 0;
        if (p < 92)
            return $urandom_range(3, 1);
        return $urandom_range(40, 5);
    endfunction

    // sender: accepted beats are predicted with the time step in force at that edge
    always @(posedge clk)
    begin
        body_t b;
        if (rst_n)
        begin
            if (!(s_tvalid && !s_tready))
            begin
                if (s_tvalid)
                begin
                    b.orient = s_tdata[127:0];
                    b.omega = s_tdata[223:128];
                    expected_attitudes.push_back(integrate_attitude(b, dt_shadow));
                    beats_in++;
                end
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_bodies.size() > 0)
                begin
                    b = pending_bodies.pop_front();
                    s_tdata <= {b.omega, b.orient};
                    s_tvalid <= 1'b1;
                    gap_left = pick_gap();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: random stalls plus one long hold-off while the sender runs without gaps
    always @(posedge clk)
    begin
        attitude_t e;
        int p;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                beats_out++;
                if (expected_attitudes.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat: %h degen %0d", m_tdata, m_tuser);
                end
                else
                begin
                    e = expected_attitudes.pop_front();
                    if (m_tuser[0])
                        degen_seen++;
                    if (m_tdata[31:0] !== e.q[0] || m_tdata[63:32] !== e.q[1] ||
                        m_tdata[95:64] !== e.q[2] || m_tdata[127:96] !== e.q[3] ||
                        m_tuser[0] !== e.degen)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch %0d: exp %h %h %h %h dg=%0d got %h %h %h %h dg=%0d",
                                     beats_out, e.q[0], e.q[1], e.q[2], e.q[3], e.degen,
                                     m_tdata[31:0], m_tdata[63:32], m_tdata[95:64],
                                     m_tdata[127:96], m_tuser[0]);
                    end
                end
            end
            if (no_gaps && !long_hold_done)
            begin
                hold_left = 400;
                long_hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                p = $urandom_range(99);
                if (no_gaps || p < 70)
                    m_tready <= 1'b1;
                else if (p < 97)
                    m_tready <= 1'b0;
                else
                begin
                    hold_left = $urandom_range(30, 5);
                    m_tready <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic body_t make_body(comp_t qx, comp_t qy, comp_t qz, comp_t qw,
                                        comp_t wx, comp_t wy, comp_t wz);
        body_t b;
        b.orient[0] = qx; b.orient[1] = qy; b.orient[2] = qz; b.orient[3] = qw;
        b.omega[0] = wx;  b.omega[1] = wy;  b.omega[2] = wz;
        return b;
    endfunction

    function automatic comp_t rand_comp(int mode);
        case (mode)
            0: return $signed($urandom_range(2 * 536870912, 0)) - 32'sd536870912;
            1: return $urandom();
            2: return $signed($urandom_range(8, 0)) - 32'sd4;
            default: return $signed($urandom_range(2097152, 0)) - 32'sd1048576;
        endcase
    endfunction

    function automatic body_t random_body();
        body_t b;
        int p, qm, wm;
        p = $urandom_range(99);
        // mostly orientations with components in [-1, 1] (Q29) and plausible rates
        qm = (p < 65) ? 0 : (p < 85) ? 1 : 2;
        wm = (p < 65) ? 3 : (p < 85) ? 1 : $urandom_range(3, 1);
        for (int i = 0; i < 4; i++)
            b.orient[i] = rand_comp(qm);
        for (int i = 0; i < 3; i++)
            b.omega[i] = rand_comp(wm);
        return b;
    endfunction

    // checked between edges so the sender's pending drive is already visible
    task automatic wait_idle();
        while (pending_bodies.size() > 0 || s_tvalid || expected_attitudes.size() > 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_time_step(step_t v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        dt_shadow = v;
        dt_writes++;
        cfg_valid <= 1'b0;
    endtask

    task automatic load_directed();
        comp_t mx, mn, one;
        mx = 32'sh7fffffff;
        mn = 32'sh80000000;
        one = ONE_Q29;
        pending_bodies.push_back(make_body(0, 0, 0, 0, 0, 0, 0));
        pending_bodies.push_back(make_body(0, 0, 0, one, 0, 0, 0));
        pending_bodies.push_back(make_body(5, 0, 0, 0, 0, 0, 0));
        pending_bodies.push_back(make_body(5, 2, 0, 0, 0, 0, 0));
        pending_bodies.push_back(make_body(0, 0, 0, -2, 0, 0, 0));
        pending_bodies.push_back(make_body(mx, mx, mx, mx, 0, 0, 0));
        pending_bodies.push_back(make_body(mn, mn, mn, mn, 0, 0, 0));
        pending_bodies.push_back(make_body(mx, mn, mx, mn, mx, mn, mx));
        pending_bodies.push_back(make_body(mn, mn, mn, mn, mn, mn, mn));
        pending_bodies.push_back(make_body(mx, mx, mx, mx, mx, mx, mx));
        pending_bodies.push_back(make_body(0, 0, 0, one, mx, 0, 0));
        pending_bodies.push_back(make_body(0, 0, 0, one, 0, mn, 0));
        pending_bodies.push_back(make_body(0, 0, 0, one, 0, 0, mx));
        pending_bodies.push_back(make_body(one, 0, 0, 0, 32'sh10000, 0, 0));
        pending_bodies.push_back(make_body(0, one, 0, 0, 0, 32'sh10000, 0));
        pending_bodies.push_back(make_body(0, 0, -one, 0, 0, 0, -32'sh10000));
        pending_bodies.push_back(make_body(1, -1, 1, -1, 0, 0, 0));
        pending_bodies.push_back(make_body(-1, 0, 0, 0, 1, 1, 1));
        pending_bodies.push_back(make_body(mx, 0, 0, 0, 0, 0, 0));
        pending_bodies.push_back(make_body(0, 0, 0, mn, 0, 0, 0));
        pending_bodies.push_back(make_body(one, one, one, one, mn, mx, mn));
    endtask

    initial
    begin
        step_t settings[6];
        settings[0] = TIME_STEP_RESET;
        settings[1] = 24'd0;
        settings[2] = 24'hffffff;
        settings[3] = 24'd1;
        settings[4] = step_t'($urandom_range(24'hffffff, 0));
        settings[5] = step_t'($urandom_range(24'h0fffff, 24'h000100));
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph > 0)
                write_time_step(settings[ph]);
            no_gaps = (ph == 3);
            load_directed();
            for (int i = 0; i < 160; i++)
                pending_bodies.push_back(random_body());
            // the next setting waits until every result of this setting is home
            wait_idle();
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_attitudes.size() > 0)
            mismatches += expected_attitudes.size();
        $display("covered %0d beats in, %0d out, %0d degenerate, %0d time step writes",
                 beats_in, beats_out, degen_seen, dt_writes);
        $display("time steps exercised: reset, zero, full scale, one lsb and two random");
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
`default_nettype wire
